// ===== rtl/tpu_argb_pkg.sv =====
package tpu_argb_pkg;

   localparam int PIXEL_WIDTH     = 32;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHANNEL_ORDER = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHANNEL_BITS  = 1'b1;

   localparam logic [7:0] CHAR_R = 8'h72;
   localparam logic [7:0] CHAR_G = 8'h67;
   localparam logic [7:0] CHAR_B = 8'h62;
   localparam logic [7:0] CHAR_A = 8'h61;

   localparam logic [31:0] ASTC_LOW  = 32'd27;
   localparam logic [31:0] ASTC_HIGH = 32'd45;

   localparam logic [6:0] BPP_ONE  = 7'd1;
   localparam logic [6:0] BPP_TWO  = 7'd2;
   localparam logic [6:0] BPP_FOUR = 7'd4;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [2:0] {
      MODE_RGBA,
      MODE_GREY,
      MODE_ORDER8,
      MODE_ORDER4,
      MODE_BAD
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] channel_order;
   } fmt_type;

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] pixel_bytes;
      logic                   last_pixel;
   } req_payload_type;

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] argb;
      logic                   unsupported;
      logic                   last_out;
   } rsp_payload_type;

endpackage

// ===== rtl/texture_pixel_unpack_argb.sv =====
// Path: a req beat is captured in the input register, then moves on to the
// result register that drives rsp_valid; rsp_stall can hold it between them.
// Throughput: one beat per cycle while rsp_stall is low; the single-pass
// convert logic sits between the two registers and never iterates.
// Reset: synchronous, active high; clears both pipeline valids and sets both
// configuration words to zero (fixed R,G,B,A order).
module texture_pixel_unpack_argb
   import tpu_argb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_payload_type            req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_payload_type            rsp_payload,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   fmt_type         fmt;
   rsp_payload_type converted;

   // stage 1: input register
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff;
   // stage 2: result register
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff;

   logic out_load;
   logic in_load;

   tpu_argb_cfg u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fmt              (fmt)
   );

   tpu_argb_convert u_convert (
      .fmt    (fmt),
      .pixel  (in_data_ff),
      .result (converted)
   );

   // result register takes a new beat whenever it is empty or draining
   assign out_load  = !out_valid_ff || !rsp_stall;
   // input register frees up when its beat moves on
   assign req_stall = in_valid_ff && !out_load;
   assign in_load   = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = in_valid_ff;
         in_valid_in  = 1'b0;
      end
      if (in_load) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_data_ff <= req_payload;
      end
      if (out_load && in_valid_ff) begin
         out_data_ff <= converted;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

`ifndef SYNTHESIS
   // unsupported beats carry a zero pixel
   a_bad_is_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.unsupported |-> rsp_payload.argb == '0)
      else $error("unsupported beat with nonzero argb");

   // both stages full and output stalled: input must stall
   a_full_stalls : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && rsp_stall |-> req_stall)
      else $error("input accepted with pipeline full");

   // a beat in stage 1 reaches the output register when it can move
   a_advance : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !(out_valid_ff && rsp_stall) |=> rsp_valid)
      else $error("stage 1 beat lost");

   // a waiting result is not overwritten or dropped
   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");
`endif

endmodule

// ===== rtl/tpu_argb_cfg.sv =====
module tpu_argb_cfg
   import tpu_argb_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output fmt_type                    fmt
);

   logic [31:0] order_ff, order_in;
   logic [31:0] bits_ff, bits_in;
   mode_type    mode_ff, mode_in;
   logic [9:0]  bit_sum;
   logic [6:0]  bpp;

   always_comb begin
      order_in = order_ff;
      bits_in  = bits_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CHANNEL_ORDER: order_in = csr_write_data;
            CSR_CHANNEL_BITS:  bits_in  = csr_write_data;
            default: ;
         endcase
      end
   end

   // decode stored words; users must let writes land only while idle,
   // which is not enforced here, so no beat sees the mode register lag
   always_comb begin
      bit_sum = {2'b00, bits_ff[7:0]} + {2'b00, bits_ff[15:8]}
              + {2'b00, bits_ff[23:16]} + {2'b00, bits_ff[31:24]};
      bpp = (bits_ff == 32'd0) ? BPP_FOUR : bit_sum[9:3];
      priority if (order_ff >= ASTC_LOW && order_ff <= ASTC_HIGH) begin
         mode_in = MODE_BAD;
      end else if (order_ff == 32'd0 && bits_ff == 32'd0) begin
         mode_in = MODE_RGBA;
      end else if (bpp == BPP_ONE) begin
         mode_in = MODE_GREY;
      end else if (bpp == BPP_FOUR) begin
         mode_in = MODE_ORDER8;
      end else if (bpp == BPP_TWO) begin
         mode_in = MODE_ORDER4;
      end else begin
         mode_in = MODE_BAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= '0;
         bits_ff  <= '0;
         mode_ff  <= MODE_RGBA;
      end else begin
         order_ff <= order_in;
         bits_ff  <= bits_in;
         mode_ff  <= mode_in;
      end
   end

   assign fmt.mode          = mode_ff;
   assign fmt.channel_order = order_ff;

endmodule

// ===== rtl/tpu_argb_convert.sv =====
module tpu_argb_convert
   import tpu_argb_pkg::*;
(
   input  fmt_type         fmt,
   input  req_payload_type pixel,
   output rsp_payload_type result
);

   // later position wins on duplicate characters
   function automatic logic [31:0] by_order(input logic [31:0] order,
                                            input logic [31:0] vals);
      logic [7:0] r, g, b, a, ch, v;
      r = 8'h00;
      g = 8'h00;
      b = 8'h00;
      a = ALPHA_OPAQUE;
      for (int k = 0; k < 4; k++) begin
         ch = order[8*k +: 8];
         v  = vals[8*k +: 8];
         if (ch == CHAR_R) r = v;
         else if (ch == CHAR_G) g = v;
         else if (ch == CHAR_B) b = v;
         else if (ch == CHAR_A) a = v;
      end
      return {a, r, g, b};
   endfunction

   logic [31:0] px;
   logic [31:0] nibs;

   assign px = pixel.pixel_bytes;
   // byte 0 high nibble first, each nibble replicated to 8 bits
   assign nibs = {px[11:8], px[11:8], px[15:12], px[15:12],
                  px[3:0], px[3:0], px[7:4], px[7:4]};

   always_comb begin
      result.last_out    = pixel.last_pixel;
      result.unsupported = 1'b0;
      result.argb        = '0;
      unique case (fmt.mode)
         MODE_RGBA:   result.argb = {px[31:24], px[7:0], px[15:8], px[23:16]};
         MODE_GREY:   result.argb = {ALPHA_OPAQUE, px[7:0], px[7:0], px[7:0]};
         MODE_ORDER8: result.argb = by_order(fmt.channel_order, px);
         MODE_ORDER4: result.argb = by_order(fmt.channel_order, nibs);
         default:     result.unsupported = 1'b1;
      endcase
   end

endmodule
